// ===== rtl/tlbpt_pkg.sv =====
// Shared constants and types for the LRU translator.
package tlbpt_pkg;

    localparam int FRAME_COUNT_DEF = 128;
    localparam int TLB_DEPTH_DEF   = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int STAMP_BITS_DEF  = 32;
    localparam int PAGE_BITS       = 8;
    localparam int OFFSET_BITS     = 8;
    localparam int PA_BITS         = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_OWNER,
        ST_EVICT,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/tlb_page_table_lru_translator.sv =====
// Top level: address translator with FIFO TLB, page table and LRU frames.
//
// One word in, one word out. On a TLB hit, a page-table hit, or a fault while
// free frames remain, the word passes through ST_LOOKUP and ST_FINISH to ST_OUT,
// where m_tvalid is high. A fault once all FRAME_COUNT frames are used runs the
// LRU scan, one frame stamp a cycle through a single comparator, and then
// ST_OWNER and ST_EVICT before ST_FINISH. After reset the page table is cleared
// by a pass over all PAGE_COUNT entries, during which s_tready stays low. The
// block takes one word at a time; s_tready is low from accept until the result
// word is taken.
module tlb_page_table_lru_translator
    import tlbpt_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int TLB_DEPTH   = TLB_DEPTH_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int STAMP_BITS  = STAMP_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] virtual_address
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] physical_address, [15] tlb_hit, [16] page_fault,
    // [17] evicted_valid, [25:18] evicted_page, [31:26] zero
    output logic [31:0] m_tdata
);

    localparam int FB = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int PB = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int TB = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

    state_t state_reg, state_next;

    // page table: valid bit packed with the frame
    logic [FB:0]   page_mem [PAGE_COUNT];
    logic [PB-1:0] owner_mem [FRAME_COUNT];
    logic [STAMP_BITS-1:0] stamp_mem [FRAME_COUNT];

    logic [PB:0]   clr_reg;
    logic          clearing;

    logic [PAGE_BITS-1:0] tlb_page_reg [TLB_DEPTH];
    logic [FB-1:0]        tlb_frame_reg [TLB_DEPTH];
    logic [TLB_DEPTH-1:0] tlb_valid_reg;
    logic [TB-1:0]        tlb_wp_reg;
    logic [FB:0]          used_reg;
    logic [STAMP_BITS-1:0] acc_reg;

    logic [PB-1:0]          page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [FB-1:0]          frame_reg;
    logic                   hit_reg, fault_reg, ev_reg;
    logic [PB-1:0]          evp_reg;

    logic [FB:0]    pm_rd_reg;
    logic [PB-1:0]  own_rd_reg;
    logic [STAMP_BITS-1:0] stamp_rd_reg;

    logic           tlb_match;
    logic [FB-1:0]  tlb_match_frame;

    logic           scan_start, scan_busy, scan_done;
    logic [FB-1:0]  scan_addr, scan_best;

    logic           pm_we;
    logic [PB-1:0]  pm_waddr;
    logic [FB:0]    pm_wdata;

    assign clearing = !clr_reg[PB];
    assign scan_start = (state_reg == ST_LOOKUP) && !tlb_match && !pm_rd_reg[FB]
                        && (used_reg == (FB+1)'(FRAME_COUNT));

    // parallel TLB compare, first matching slot wins
    always_comb
    begin
        tlb_match       = 1'b0;
        tlb_match_frame = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == PAGE_BITS'(page_reg)))
            begin
                tlb_match       = 1'b1;
                tlb_match_frame = tlb_frame_reg[i];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid && !clearing) state_next = ST_LOOKUP;
            ST_LOOKUP:
            begin
                if (tlb_match || pm_rd_reg[FB]) state_next = ST_FINISH;
                else if (scan_start)            state_next = ST_SCAN;
                else                            state_next = ST_FINISH;
            end
            ST_SCAN:   if (scan_done) state_next = ST_OWNER;
            ST_OWNER:  state_next = ST_EVICT;
            ST_EVICT:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // page-table write port: clear pass, evict, or map
    always_comb
    begin
        pm_we    = 1'b0;
        pm_waddr = page_reg;
        pm_wdata = {1'b1, frame_reg};
        if (clearing)
        begin
            pm_we    = 1'b1;
            pm_waddr = clr_reg[PB-1:0];
            pm_wdata = '0;
        end
        else if (state_reg == ST_EVICT && pm_rd_reg[FB])
        begin
            pm_we    = 1'b1;
            pm_waddr = own_rd_reg;
            pm_wdata = '0;
        end
        else if (state_reg == ST_FINISH && fault_reg)
        begin
            pm_we = 1'b1;
        end
    end

    // memories: one write, registered reads
    always_ff @(posedge clk)
    begin
        if (pm_we)
            page_mem[pm_waddr] <= pm_wdata;
        if (state_reg == ST_IDLE)
            pm_rd_reg <= page_mem[PB'(s_tdata[15:8])];
        else
            pm_rd_reg <= page_mem[(state_reg == ST_OWNER) ? own_rd_reg : page_reg];
        own_rd_reg <= owner_mem[scan_best];
        if (state_reg == ST_FINISH && fault_reg)
            owner_mem[frame_reg] <= page_reg;
        stamp_rd_reg <= stamp_mem[scan_addr];
        if (state_reg == ST_FINISH)
            stamp_mem[frame_reg] <= acc_reg;
    end

    tlbpt_lru_scan #(
        .FRAME_COUNT(FRAME_COUNT),
        .STAMP_BITS (STAMP_BITS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_start),
        .busy   (scan_busy),
        .done   (scan_done),
        .rd_addr(scan_addr),
        .rd_data(stamp_rd_reg),
        .best   (scan_best)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_reg       <= '0;
            tlb_valid_reg <= '0;
            tlb_wp_reg    <= '0;
            used_reg      <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= (clr_reg == (PB+1)'(PAGE_COUNT - 1)) ? {1'b1, PB'(0)}
                                                                 : clr_reg + 1'b1;
            // drop stale TLB entries of the evicted page
            if (state_reg == ST_EVICT && pm_rd_reg[FB])
                for (int i = 0; i < TLB_DEPTH; i++)
                    if (tlb_page_reg[i] == PAGE_BITS'(own_rd_reg))
                        tlb_valid_reg[i] <= 1'b0;
            if (state_reg == ST_FINISH)
            begin
                if (!hit_reg)
                begin
                    tlb_valid_reg[tlb_wp_reg] <= 1'b1;
                    tlb_wp_reg <= (tlb_wp_reg == TB'(TLB_DEPTH - 1)) ? '0 : tlb_wp_reg + 1'b1;
                end
                if (fault_reg && used_reg < (FB+1)'(FRAME_COUNT))
                    used_reg <= used_reg + 1'b1;
                if (acc_reg != STAMP_MAX)
                    acc_reg <= acc_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                page_reg   <= PB'(s_tdata[15:8]);
                offset_reg <= s_tdata[7:0];
                hit_reg    <= 1'b0;
                fault_reg  <= 1'b0;
                ev_reg     <= 1'b0;
                evp_reg    <= '0;
            end
            ST_LOOKUP:
            begin
                if (tlb_match)
                begin
                    hit_reg   <= 1'b1;
                    frame_reg <= tlb_match_frame;
                end
                else if (pm_rd_reg[FB])
                    frame_reg <= pm_rd_reg[FB-1:0];
                else
                begin
                    fault_reg <= 1'b1;
                    frame_reg <= used_reg[FB-1:0];
                end
            end
            ST_SCAN:  if (scan_done) frame_reg <= scan_best;
            ST_EVICT:
            begin
                if (pm_rd_reg[FB])
                begin
                    ev_reg  <= 1'b1;
                    evp_reg <= own_rd_reg;
                end
            end
            ST_FINISH:
            begin
                if (!hit_reg)
                begin
                    tlb_page_reg[tlb_wp_reg]  <= PAGE_BITS'(page_reg);
                    tlb_frame_reg[tlb_wp_reg] <= frame_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !clearing;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, PAGE_BITS'(evp_reg), ev_reg, fault_reg, hit_reg,
                       PA_BITS'({frame_reg, offset_reg})};

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("in and out open together");
    a_hit_nofault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[15] && m_tdata[16])) else $error("hit with fault");
    a_ev_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[17] |-> m_tdata[16]) else $error("evict w/o fault");
    a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
        scan_busy |-> used_reg == (FB+1)'(FRAME_COUNT)) else $error("scan early");

endmodule

// ===== rtl/tlbpt_lru_scan.sv =====
// Serial minimum search over the frame stamps, one frame per cycle.
module tlbpt_lru_scan
    import tlbpt_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int STAMP_BITS  = STAMP_BITS_DEF,
    localparam int FB = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    output logic [FB-1:0]         rd_addr,
    input  logic [STAMP_BITS-1:0] rd_data,
    output logic [FB-1:0]         best
);

    logic [FB:0]           idx_reg, idx_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  first_reg, first_next;
    logic [FB-1:0]         best_reg, best_next;
    logic [STAMP_BITS-1:0] min_reg, min_next;
    logic [FB-1:0]         cand_reg, cand_next;
    logic                  cand_ok_reg, cand_ok_next;

    // read address leads the compare, which sees the registered memory read
    always_comb
    begin
        idx_next     = idx_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        first_next   = first_reg;
        best_next    = best_reg;
        min_next     = min_reg;
        cand_next    = idx_reg[FB-1:0];
        cand_ok_next = 1'b0;
        if (start)
        begin
            idx_next   = '0;
            busy_next  = 1'b1;
            first_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (idx_reg < (FB+1)'(FRAME_COUNT))
            begin
                cand_ok_next = 1'b1;
                idx_next     = idx_reg + 1'b1;
            end
            if (cand_ok_reg)
            begin
                if (first_reg || (rd_data < min_reg))
                begin
                    min_next  = rd_data;
                    best_next = cand_reg;
                end
                first_next = 1'b0;
                if (cand_reg == FB'(FRAME_COUNT - 1))
                begin
                    busy_next    = 1'b0;
                    done_next    = 1'b1;
                    cand_ok_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            first_reg   <= 1'b0;
            cand_ok_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            first_reg   <= first_next;
            cand_ok_reg <= cand_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        min_reg  <= min_next;
        cand_reg <= cand_next;
    end

    assign rd_addr = idx_reg[FB-1:0];
    assign busy    = busy_reg;
    assign done    = done_reg;
    assign best    = best_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("busy after done");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= (FB+1)'(FRAME_COUNT)) else $error("index overrun");

endmodule
